[rtl/erac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erac_pkg: shared types, constants and sine table for the rotate block
// Holds the coordinate and working widths, the config register codes, and the
// quarter-wave sine table in Q1.14 with its lookup helpers.
// ----------------------------------------------------------------------------
package erac_pkg;

  localparam int COORD_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TBL_SIZE        = 1 << SINE_TABLE_BITS;
  localparam int QUARTER         = TBL_SIZE / 4;
  localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
  localparam int ANGLE_W         = 16;
  localparam int TRIG_W          = 16;
  localparam int FRAC_BITS       = 14;
  // Each rotation grows a value by at most sqrt(2); keep headroom for three
  // rotations on top of the centered difference.
  localparam int ROT_W           = COORD_BITS + 4;
  localparam int PROD_W          = ROT_W + TRIG_W;
  localparam int SUM_W           = PROD_W + 1;
  localparam int DATA_W          = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W       = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ROT_W-1:0]      wide_t;
  typedef logic signed [TRIG_W-1:0]     trig_val_t;

  typedef struct packed {
    trig_val_t c;
    trig_val_t s;
  } trig_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    trig_t  rot_x;
    trig_t  rot_y;
    trig_t  rot_z;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_ANGLE_X  = 3'd3,
    REG_ANGLE_Y  = 3'd4,
    REG_ANGLE_Z  = 3'd5
  } cfg_reg_t;

  typedef trig_val_t qtr_tab_t [0:QUARTER];

  // sin(2*pi*k/TBL_SIZE) in Q1.14 by Taylor series in Q30, for 0 <= k <= QUARTER
  function automatic trig_val_t quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'd6746518852 * 64'(k)) >> SINE_TABLE_BITS;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      unique case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        default: term = term / 64'd420;
      endcase
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (64'(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return trig_val_t'(r[TRIG_W-1:0]);
  endfunction

  function automatic qtr_tab_t build_qtr_tab();
    qtr_tab_t tab;
    for (int k = 0; k <= QUARTER; k++) begin
      tab[k] = quarter_sine(k);
    end
    return tab;
  endfunction

  localparam qtr_tab_t SINE_QTR = build_qtr_tab();

  // Full-turn sine from the quarter table by quadrant symmetry
  function automatic trig_val_t table_sine(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]          q;
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS:0]   k;
    trig_val_t           v;
    q = idx[SINE_TABLE_BITS-1 -: 2];
    r = idx[QTR_BITS-1:0];
    k = q[0] ? ((QTR_BITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    v = SINE_QTR[k];
    return q[1] ? -v : v;
  endfunction

  // Cosine reads a quarter turn further on, wrapping around the table
  function automatic trig_t angle_trig(input logic [ANGLE_W-1:0] angle);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-1:0] idx_c;
    trig_t                      t;
    idx   = angle[ANGLE_W-1 -: SINE_TABLE_BITS];
    idx_c = idx + SINE_TABLE_BITS'(QUARTER);
    t.s   = table_sine(idx);
    t.c   = table_sine(idx_c);
    return t;
  endfunction

  localparam trig_t TRIG_ZERO = '{c: trig_val_t'(16384), s: trig_val_t'(0)};

endpackage

[rtl/erac_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erac_cfg: configuration registers
// Holds the rotation center and, per axis, the cosine and sine looked up from
// the table when the angle is written.
// ----------------------------------------------------------------------------
module erac_cfg
  import erac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.center_z <= '0;
      cfg.rot_x    <= TRIG_ZERO;
      cfg.rot_y    <= TRIG_ZERO;
      cfg.rot_z    <= TRIG_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg.center_x <= coord_t'(cfg_data);
        REG_CENTER_Y: cfg.center_y <= coord_t'(cfg_data);
        REG_CENTER_Z: cfg.center_z <= coord_t'(cfg_data);
        REG_ANGLE_X:  cfg.rot_x    <= angle_trig(cfg_data[ANGLE_W-1:0]);
        REG_ANGLE_Y:  cfg.rot_y    <= angle_trig(cfg_data[ANGLE_W-1:0]);
        REG_ANGLE_Z:  cfg.rot_z    <= angle_trig(cfg_data[ANGLE_W-1:0]);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

[rtl/erac_rot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erac_rot: one planar rotation, two pipeline stages
// Stage 1 registers the four products, stage 2 combines them and rounds half up
// back to the coordinate scale. A third coordinate rides along unchanged.
// ----------------------------------------------------------------------------
module erac_rot
  import erac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  trig_t trig,
  input  logic  in_valid,
  output logic  in_ready,
  input  wide_t in_a,
  input  wide_t in_b,
  input  wide_t in_p,
  output logic  out_valid,
  input  logic  out_ready,
  output wide_t out_a,
  output wide_t out_b,
  output wide_t out_p
);

  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1 << (FRAC_BITS - 1));

  logic                     v1;
  logic                     v2;
  logic                     rdy1;
  logic                     rdy2;
  logic signed [PROD_W-1:0] ca;
  logic signed [PROD_W-1:0] sb;
  logic signed [PROD_W-1:0] sa;
  logic signed [PROD_W-1:0] cb;
  wide_t                    p1;
  logic signed [SUM_W-1:0]  sum_a;
  logic signed [SUM_W-1:0]  sum_b;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ca <= PROD_W'(trig.c) * PROD_W'(in_a);
      sb <= PROD_W'(trig.s) * PROD_W'(in_b);
      sa <= PROD_W'(trig.s) * PROD_W'(in_a);
      cb <= PROD_W'(trig.c) * PROD_W'(in_b);
      p1 <= in_p;
    end
  end

  // Stage 2: combine, round half up, floor shift
  assign sum_a = SUM_W'(ca) - SUM_W'(sb) + ROUND;
  assign sum_b = SUM_W'(sa) + SUM_W'(cb) + ROUND;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      out_a <= ROT_W'(sum_a >>> FRAC_BITS);
      out_b <= ROT_W'(sum_b >>> FRAC_BITS);
      out_p <= p1;
    end
  end

  assign out_valid = v2;

endmodule

[rtl/euler_rotate_about_center.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_rotate_about_center: rotate a vertex about a configured center point
// Subtracts the center, rotates about X, then Y, then Z, adds the center back
// and saturates each coordinate to the signed Q16.16 range.
// ----------------------------------------------------------------------------
// Usage: the block takes one vertex per cycle while s_tready is high and returns
// one rotated vertex per vertex, in order. An accepted vertex passes through every
// stage before it shows on m_tvalid: one stage subtracts the center, each of the
// three axis rotations takes two stages (a register of four products, then the
// combine and round), and the last stage adds the center back and saturates.
// Every stage has its own valid bit and takes a new item whenever it is empty or
// its successor moves on, so bubbles close up and s_tready only drops when all
// eight stages hold items and the output is stalled. Angle writes look up sine
// and cosine at write time, so a new angle applies to the next vertex accepted.
// Write configuration only while no vertex is in flight.
// ----------------------------------------------------------------------------
module euler_rotate_about_center
  import erac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  // Vertex in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,   // in_x, in_y, in_z from bit 0 up
  // Rotated vertex out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // out_x, out_y, out_z from bit 0 up
  output logic [0:0]            m_tuser    // saturated
);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic   sat;
    coord_t val;
  } clip_t;

  // Add the center back and clip to the coordinate range
  function automatic clip_t clip(input wide_t v, input coord_t c);
    logic signed [ROT_W:0] s;
    clip_t                 r;
    s = (ROT_W+1)'(v) + (ROT_W+1)'(c);
    if (s > (ROT_W+1)'(COORD_MAX)) begin
      r.sat = 1'b1;
      r.val = COORD_MAX;
    end else if (s < (ROT_W+1)'(COORD_MIN)) begin
      r.sat = 1'b1;
      r.val = COORD_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = coord_t'(s[COORD_BITS-1:0]);
    end
    return r;
  endfunction

  cfg_t   cfg;

  // Center-subtract stage
  logic   va;
  logic   rdy_a;
  wide_t  dx;
  wide_t  dy;
  wide_t  dz;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;

  // Rotation stage handshakes and data
  logic   rx_ready;
  logic   rx_valid;
  wide_t  x1;
  wide_t  y1;
  wide_t  z1;
  logic   ry_ready;
  logic   ry_valid;
  wide_t  x2;
  wide_t  y2;
  wide_t  z2;
  logic   rz_ready;
  logic   rz_valid;
  wide_t  x3;
  wide_t  y3;
  wide_t  z3;

  // Output register
  logic   rdy_out;
  coord_t ox;
  coord_t oy;
  coord_t oz;
  logic   osat;
  clip_t  cx;
  clip_t  cy;
  clip_t  cz;

  erac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the input item
  assign in_x = coord_t'(s_tdata[COORD_BITS-1:0]);
  assign in_y = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign in_z = coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);

  assign rdy_a    = !va || rx_ready;
  assign s_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= s_tvalid;
    end
  end

  // Move the vertex to the center frame at full width
  always_ff @(posedge clk) begin
    if (rdy_a && s_tvalid) begin
      dx <= wide_t'(in_x) - wide_t'(cfg.center_x);
      dy <= wide_t'(in_y) - wide_t'(cfg.center_y);
      dz <= wide_t'(in_z) - wide_t'(cfg.center_z);
    end
  end

  // About X: pair (y, z)
  erac_rot u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .trig      (cfg.rot_x),
    .in_valid  (va),
    .in_ready  (rx_ready),
    .in_a      (dy),
    .in_b      (dz),
    .in_p      (dx),
    .out_valid (rx_valid),
    .out_ready (ry_ready),
    .out_a     (y1),
    .out_b     (z1),
    .out_p     (x1)
  );

  // About Y: pair (x, z)
  erac_rot u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .trig      (cfg.rot_y),
    .in_valid  (rx_valid),
    .in_ready  (ry_ready),
    .in_a      (x1),
    .in_b      (z1),
    .in_p      (y1),
    .out_valid (ry_valid),
    .out_ready (rz_ready),
    .out_a     (x2),
    .out_b     (z2),
    .out_p     (y2)
  );

  // About Z: pair (x, y)
  erac_rot u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .trig      (cfg.rot_z),
    .in_valid  (ry_valid),
    .in_ready  (rz_ready),
    .in_a      (x2),
    .in_b      (y2),
    .in_p      (z2),
    .out_valid (rz_valid),
    .out_ready (rdy_out),
    .out_a     (x3),
    .out_b     (y3),
    .out_p     (z3)
  );

  // Final stage: add the center back, saturate, hold until taken
  assign rdy_out = !m_tvalid || m_tready;
  assign cx      = clip(x3, cfg.center_x);
  assign cy      = clip(y3, cfg.center_y);
  assign cz      = clip(z3, cfg.center_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_out) begin
      m_tvalid <= rz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && rz_valid) begin
      ox   <= cx.val;
      oy   <= cy.val;
      oz   <= cz.val;
      osat <= cx.sat || cy.sat || cz.sat;
    end
  end

  assign m_tdata = DATA_W'({oz, oy, ox});
  assign m_tuser = osat;

  // An empty output stage lets every stage behind it advance
  a_ready_when_out_empty : assert property (@(posedge clk)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // The saturation flag only marks a result clipped to a range limit
  a_sat_means_limit : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && osat) |-> (ox == COORD_MAX || ox == COORD_MIN ||
                            oy == COORD_MAX || oy == COORD_MIN ||
                            oz == COORD_MAX || oz == COORD_MIN))
    else $error("saturated flag set without a clipped coordinate");

  // Reset empties the output stage
  a_reset_clears_out : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the vertex rotate-about-center block
// Streams vertices through the block under a series of center and angle
// settings. An in-bench model predicts each rotated vertex at its acceptance,
// and the monitor compares every output item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import erac_pkg::*;
();

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int CHUNK_ITEMS    = 88;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 4000;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;
  localparam logic [31:0] Q_TURN  = 32'h0000_4000;
  localparam logic [31:0] H_TURN  = 32'h0000_8000;
  localparam logic [31:0] TQ_TURN = 32'h0000_c000;
  localparam logic [31:0] E_TURN  = 32'h0000_2000;

  localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  // Idle percentages per phase: none, sender only, receiver only, both
  localparam int SEND_IDLE  [4] = '{0, 49, 0, 19};
  localparam int RECV_STALL [4] = '{0, 0, 49, 19};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } vertex_result_t;

  typedef struct packed {
    longint a;
    longint b;
  } pair_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [DATA_W-1:0]     m_tdata;
  logic [0:0]            m_tuser;

  // Model copy of the registers
  coord_t      pivot_x = '0;
  coord_t      pivot_y = '0;
  coord_t      pivot_z = '0;
  logic [15:0] turn_x  = '0;
  logic [15:0] turn_y  = '0;
  logic [15:0] turn_z  = '0;

  int sine_quarter [0:QUARTER];

  logic [DATA_W-1:0] vertex_q  [$];
  vertex_result_t    rotated_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  euler_rotate_about_center u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Rotation model
  // --------------------------------------------------------------------------

  // First-quadrant sine in Q1.14 from a Taylor series evaluated in Q30
  function automatic int series_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    longint unsigned r;
    x    = (64'd6746518852 * longint'(k)) >> SINE_TABLE_BITS;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (longint'(acc) + 32768) >> 16;
    return (r > 16384) ? 16384 : int'(r);
  endfunction

  // Full-turn sine by quadrant symmetry of the quarter table
  function automatic longint wave_at(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [SINE_TABLE_BITS-3:0] r;
    longint                     v;
    r = idx[SINE_TABLE_BITS-3:0];
    v = idx[SINE_TABLE_BITS-2] ? sine_quarter[QUARTER - int'(r)] : sine_quarter[r];
    return idx[SINE_TABLE_BITS-1] ? -v : v;
  endfunction

  // Rotate one coordinate pair, rounding half up; arithmetic shift is a floor
  function automatic pair_t turn_pair(input longint a, input longint b,
                                      input logic [15:0] angle);
    logic [SINE_TABLE_BITS-1:0] idx_s;
    logic [SINE_TABLE_BITS-1:0] idx_c;
    longint                     c;
    longint                     s;
    pair_t                      p;
    idx_s = angle[15 -: SINE_TABLE_BITS];
    idx_c = idx_s + SINE_TABLE_BITS'(QUARTER);
    s     = wave_at(idx_s);
    c     = wave_at(idx_c);
    p.a   = (c * a - s * b + 8192) >>> 14;
    p.b   = (s * a + c * b + 8192) >>> 14;
    return p;
  endfunction

  // Returns {clipped, value}
  function automatic logic [COORD_BITS:0] clip_coord(input longint v);
    if (v > COORD_HI) begin
      return {1'b1, COORD_HI[COORD_BITS-1:0]};
    end
    if (v < COORD_LO) begin
      return {1'b1, COORD_LO[COORD_BITS-1:0]};
    end
    return {1'b0, v[COORD_BITS-1:0]};
  endfunction

  function automatic vertex_result_t predict_rotation(input logic [DATA_W-1:0] word);
    longint                x;
    longint                y;
    longint                z;
    pair_t                 p;
    logic [COORD_BITS:0]   kx;
    logic [COORD_BITS:0]   ky;
    logic [COORD_BITS:0]   kz;
    vertex_result_t        r;
    x  = longint'(coord_t'(word[0*COORD_BITS +: COORD_BITS])) - longint'(pivot_x);
    y  = longint'(coord_t'(word[1*COORD_BITS +: COORD_BITS])) - longint'(pivot_y);
    z  = longint'(coord_t'(word[2*COORD_BITS +: COORD_BITS])) - longint'(pivot_z);
    p  = turn_pair(y, z, turn_x);
    y  = p.a;
    z  = p.b;
    p  = turn_pair(x, z, turn_y);
    x  = p.a;
    z  = p.b;
    p  = turn_pair(x, y, turn_z);
    x  = p.a;
    y  = p.b;
    kx = clip_coord(x + longint'(pivot_x));
    ky = clip_coord(y + longint'(pivot_y));
    kz = clip_coord(z + longint'(pivot_z));
    r.x   = kx[COORD_BITS-1:0];
    r.y   = ky[COORD_BITS-1:0];
    r.z   = kz[COORD_BITS-1:0];
    r.sat = kx[COORD_BITS] | ky[COORD_BITS] | kz[COORD_BITS];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed pending vertices, predict each one at the edge it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        rotated_q.push_back(predict_rotation(s_tdata));
      end
      // Hold the current item until taken; only then offer the next one
      if (!s_tvalid || s_tready) begin
        if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= vertex_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, result check, and a watchdog on progress
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    vertex_result_t want;
    if (rst) begin
      m_tready    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t unexpected item: expected none actual %h sat %b",
                   $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = rotated_q.pop_front();
          compare_field("out_x", want.x, m_tdata[0*COORD_BITS +: COORD_BITS]);
          compare_field("out_y", want.y, m_tdata[1*COORD_BITS +: COORD_BITS]);
          compare_field("out_z", want.z, m_tdata[2*COORD_BITS +: COORD_BITS]);
          compare_field("saturated", {31'd0, want.sat}, {31'd0, m_tuser[0]});
        end
      end
      // Drop the run if neither side moves an item for too long
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired with %0d results pending", $time,
                 rotated_q.size());
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register and mirror it into the model; the block is idle here
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CENTER_X: pivot_x = data;
      REG_CENTER_Y: pivot_y = data;
      REG_CENTER_Z: pivot_z = data;
      REG_ANGLE_X:  turn_x  = data[15:0];
      REG_ANGLE_Y:  turn_y  = data[15:0];
      REG_ANGLE_Z:  turn_z  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_pose(input logic [31:0] cx, input logic [31:0] cy,
                          input logic [31:0] cz, input logic [31:0] ax,
                          input logic [31:0] ay, input logic [31:0] az);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_ANGLE_X, ax);
    write_reg(REG_ANGLE_Y, ay);
    write_reg(REG_ANGLE_Z, az);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
    vertex_q.push_back({z, y, x});
  endtask

  // Wait until every queued vertex has been sent and every taken vertex has come back
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (vertex_q.size() != 0 || s_tvalid || rotated_q.size() != 0);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return MAX_POS;
      1:       return MAX_NEG;
      2:       return 32'(signed'($urandom_range(16)) - 8);
      3, 4, 5: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // Angles carry junk in the upper half so that only the low 16 bits count
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(7))
      0:       return {16'($urandom()), 2'($urandom_range(3)), 14'd0};
      1:       return {16'($urandom()), 16'hffff};
      default: return $urandom();
    endcase
  endfunction

  task automatic random_pose();
    if ($urandom_range(3) == 0) begin
      write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
    end
    set_pose(pick_coord(), pick_coord(), pick_coord(),
             pick_angle(), pick_angle(), pick_angle());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      sine_quarter[k] = series_sine(k);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset pose is the identity: coordinate extremes pass unchanged
    queue_vertex(32'd0, 32'd0, 32'd0);
    queue_vertex(MAX_POS, MAX_NEG, 32'hffff_ffff);
    queue_vertex(MAX_NEG, MAX_POS, 32'd1);
    queue_vertex(32'h0001_0000, 32'hfffe_8000, 32'h1234_5678);
    wait_drained();

    // Quarter turns on every axis; negative extremes overflow when negated.
    // Writes to unused indexes go first and must leave the pose alone.
    write_reg(REG_SPARE_A, 32'hffff_ffff);
    write_reg(REG_SPARE_B, MAX_NEG);
    set_pose(32'd0, 32'd0, 32'd0, Q_TURN, Q_TURN, Q_TURN);
    queue_vertex(MAX_POS, MAX_POS, MAX_POS);
    queue_vertex(MAX_NEG, MAX_NEG, MAX_NEG);
    queue_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    wait_drained();

    // Centers at the extremes push the centered differences past 32 bits
    set_pose(MAX_POS, MAX_NEG, MAX_POS, H_TURN, E_TURN, TQ_TURN);
    queue_vertex(MAX_NEG, MAX_POS, MAX_NEG);
    queue_vertex(32'd0, 32'd0, 32'd0);
    queue_vertex(MAX_POS, MAX_NEG, 32'd0);
    wait_drained();

    // Top angle, an angle below one table step, and exactly one step
    set_pose(MAX_NEG, MAX_POS, 32'd0, 32'hffff_ffff, 32'h0000_003f, 32'h0000_0040);
    queue_vertex(MAX_POS, MAX_NEG, MAX_POS);
    queue_vertex(32'hffff_ffff, 32'd1, 32'd0);
    queue_vertex(32'h0001_2345, 32'hfffe_dcbb, 32'h0000_8000);
    wait_drained();

    // Small values around the center to exercise round half up
    set_pose(32'h0000_8000, 32'hffff_f000, 32'd0,
             32'h0000_1555, 32'h0000_1234, 32'h0000_abcd);
    queue_vertex(32'd1, 32'hffff_ffff, 32'd2);
    queue_vertex(32'h0000_7fff, 32'hffff_8001, 32'd3);
    queue_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    wait_drained();

    // Random poses and vertices under each idling mix; drain between chunks
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct  = SEND_IDLE[mode];
      recv_stall_pct = RECV_STALL[mode];
      for (int chunk = 0; chunk < 2; chunk++) begin
        random_pose();
        repeat (CHUNK_ITEMS) begin
          queue_vertex(pick_coord(), pick_coord(), pick_coord());
        end
        wait_drained();
      end
    end

    // Let any stray output show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && rotated_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/erac_pkg.sv
rtl/erac_cfg.sv
rtl/erac_rot.sv
rtl/euler_rotate_about_center.sv
test/tb_top.sv
